[rtl/fpa_pkg.sv]
// Shared types and codes for the flash page allocator.
`timescale 1ns / 1ps
package fpa_pkg;
  typedef enum logic [1:0] {
    ACT_WRITE    = 2'd0,
    ACT_ALLOC    = 2'd1,
    ACT_RELOCATE = 2'd2,
    ACT_NONE     = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    KIND_FREE     = 2'd0,
    KIND_RESERVED = 2'd1,
    KIND_LIVE     = 2'd2,
    KIND_STALE    = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_NO_CAPACITY = 2'd1,
    ST_NOT_FOUND   = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ALLOC,
    S_RESV,
    S_LIVE,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] atom;
    logic       copy;
  } entry_t;

  typedef struct packed {
    logic   shift;
    logic   load;
    entry_t wr_entry;
  } cell_ctrl_t;
endpackage

[rtl/fpa_cell.sv]
// One page entry of the rotating table.
`timescale 1ns / 1ps
module fpa_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  fpa_pkg::cell_ctrl_t ctrl_i,
  input  logic               sel_i,
  input  fpa_pkg::entry_t    prev_i,
  output fpa_pkg::entry_t    entry_o
);
  fpa_pkg::entry_t entry_d, entry_q;

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.shift) begin
      entry_d = prev_i;
    end else if (ctrl_i.load && sel_i) begin
      entry_d = ctrl_i.wr_entry;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '0;
    end else begin
      entry_q <= entry_d;
    end
  end

  assign entry_o = entry_q;
endmodule

[rtl/flash_page_allocator_relocation.sv]
// Top level: page table held as a ring of cells, scanned by rotation.
`timescale 1ns / 1ps
// The page table lives in a ring of one cell per page. Allocate rotates
// the ring once and relocate rotates it twice: the head cell is inspected
// once per cycle and the ring returns to its original order at the end of
// each pass. busy is high from acceptance until the result strobe; the
// result is shown for one cycle on done_o and cannot be held off.
module flash_page_allocator_relocation #(
  parameter int PAGES_PER_BLOCK = 8,
  parameter int DATA_BLOCKS     = 8,
  parameter int ATOM_COUNT      = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] action_i,
  input  logic [2:0] entry_block_i,
  input  logic [2:0] entry_page_i,
  input  logic [1:0] entry_kind_i,
  input  logic [7:0] entry_atom_i,
  input  logic       entry_is_copy_i,
  output logic       done_o,
  output logic [1:0] status_o,
  output logic [2:0] chosen_block_o,
  output logic [2:0] chosen_page_o,
  output logic [7:0] moved_atom_o,
  output logic [2:0] target_block_o
);
  localparam int Total = PAGES_PER_BLOCK * DATA_BLOCKS;
  localparam int IW = (Total > 1) ? $clog2(Total) : 1;
  localparam int PW = (PAGES_PER_BLOCK > 1) ? $clog2(PAGES_PER_BLOCK) : 1;
  localparam int BW = (DATA_BLOCKS > 1) ? $clog2(DATA_BLOCKS) : 1;
  localparam int CW = $clog2(Total + 1);

  fpa_pkg::state_e    state_q, state_d;
  fpa_pkg::cell_ctrl_t ctrl;
  fpa_pkg::entry_t    ent [Total];
  fpa_pkg::entry_t    head;
  logic [Total-1:0]   sel;

  logic [1:0] act_q;
  logic [IW-1:0] widx_q;
  logic       wvalid_q;
  fpa_pkg::entry_t wentry_q;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [PW-1:0] pg_q, pg_d;
  logic [BW-1:0] bk_q, bk_d;
  logic       found_q, found_d;
  logic       allres_q, allres_d;
  logic       haveres_q, haveres_d;
  logic [BW-1:0] resv_q, resv_d;
  logic [1:0] live_n_q, live_n_d;
  logic [PW-1:0] live_pg_q, live_pg_d;
  logic [7:0] live_atom_q, live_atom_d;
  logic       live_copy_q, live_copy_d;
  logic [1:0] st_q, st_d;
  logic [2:0] cb_q, cb_d, cp_q, cp_d, tb_q, tb_d;
  logic [7:0] ma_q, ma_d;
  logic       done_q, done_d;
  logic       blk_end, wr_inrange;
  logic       accept;

  assign accept = start && !busy;
  assign head   = ent[0];
  assign blk_end = (32'(pg_q) == PAGES_PER_BLOCK - 1);
  assign wr_inrange = (32'(entry_block_i) < DATA_BLOCKS) &&
                      (32'(entry_page_i) < PAGES_PER_BLOCK);

  for (genvar i = 0; i < Total; i++) begin : g_cell
    assign sel[i] = (widx_q == IW'(i)) && wvalid_q;
    fpa_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl),
      .sel_i  (sel[i]),
      .prev_i (ent[(i + 1) % Total]),
      .entry_o(ent[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fpa_pkg::S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  // allocate writes the found page through the same load path
  always_ff @(posedge clk_i) begin
    if (accept) begin
      act_q    <= action_i;
      widx_q   <= IW'(32'(entry_block_i) * PAGES_PER_BLOCK + 32'(entry_page_i));
      wvalid_q <= wr_inrange;
      wentry_q <= '{kind: entry_kind_i, atom: entry_atom_i, copy: entry_is_copy_i};
    end else if (state_q == fpa_pkg::S_ALLOC && !found_q &&
                 head.kind == fpa_pkg::KIND_FREE) begin
      widx_q   <= IW'(cnt_q);
      wvalid_q <= 1'b1;
      wentry_q <= '{kind: fpa_pkg::KIND_RESERVED, atom: head.atom, copy: head.copy};
    end
    cnt_q <= cnt_d; pg_q <= pg_d; bk_q <= bk_d; found_q <= found_d;
    allres_q <= allres_d; haveres_q <= haveres_d; resv_q <= resv_d;
    live_n_q <= live_n_d; live_pg_q <= live_pg_d;
    live_atom_q <= live_atom_d; live_copy_q <= live_copy_d;
    st_q <= st_d; cb_q <= cb_d; cp_q <= cp_d; ma_q <= ma_d; tb_q <= tb_d;
  end

  always_comb begin
    state_d = state_q;
    done_d = 1'b0;
    ctrl = '{shift: 1'b0, load: 1'b0, wr_entry: wentry_q};
    cnt_d = cnt_q; pg_d = pg_q; bk_d = bk_q; found_d = found_q;
    allres_d = allres_q; haveres_d = haveres_q; resv_d = resv_q;
    live_n_d = live_n_q; live_pg_d = live_pg_q;
    live_atom_d = live_atom_q; live_copy_d = live_copy_q;
    st_d = st_q; cb_d = cb_q; cp_d = cp_q; ma_d = ma_q; tb_d = tb_q;
    case (state_q)
      fpa_pkg::S_IDLE: begin
        if (accept) begin
          cnt_d = '0; pg_d = '0; bk_d = '0; found_d = 1'b0;
          allres_d = 1'b1; haveres_d = 1'b0; resv_d = '0;
          live_n_d = '0;
          st_d = fpa_pkg::ST_OK; cb_d = '0; cp_d = '0; ma_d = '0; tb_d = '0;
          case (fpa_pkg::action_e'(action_i))
            fpa_pkg::ACT_ALLOC:    state_d = fpa_pkg::S_ALLOC;
            fpa_pkg::ACT_RELOCATE: state_d = fpa_pkg::S_RESV;
            default:               state_d = fpa_pkg::S_DONE;
          endcase
        end
      end
      fpa_pkg::S_ALLOC: begin
        ctrl.shift = 1'b1;
        if (!found_q && head.kind == fpa_pkg::KIND_FREE) begin
          found_d = 1'b1;
          cb_d = 3'(bk_q); cp_d = 3'(pg_q);
        end
        pg_d = blk_end ? '0 : pg_q + 1'b1;
        if (blk_end) bk_d = bk_q + 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (32'(cnt_q) == Total - 1) begin
          state_d = fpa_pkg::S_DONE;
        end
      end
      fpa_pkg::S_RESV: begin
        ctrl.shift = 1'b1;
        if (blk_end) begin
          if (allres_q && head.kind == fpa_pkg::KIND_RESERVED) begin
            haveres_d = 1'b1; resv_d = bk_q;
          end
          allres_d = 1'b1;
        end else if (head.kind != fpa_pkg::KIND_RESERVED) begin
          allres_d = 1'b0;
        end
        pg_d = blk_end ? '0 : pg_q + 1'b1;
        if (blk_end) bk_d = bk_q + 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (32'(cnt_q) == Total - 1) begin
          state_d = fpa_pkg::S_LIVE;
          cnt_d = '0; pg_d = '0; bk_d = '0; live_n_d = '0;
        end
      end
      fpa_pkg::S_LIVE: begin
        ctrl.shift = 1'b1;
        begin
          logic [1:0] n;
          logic [PW-1:0] lp;
          logic [7:0] la;
          logic lc;
          n = live_n_q; lp = live_pg_q; la = live_atom_q; lc = live_copy_q;
          if (head.kind == fpa_pkg::KIND_LIVE) begin
            n = (live_n_q == 2'd2) ? 2'd2 : live_n_q + 1'b1;
            lp = pg_q; la = head.atom; lc = head.copy;
          end
          live_n_d = n; live_pg_d = lp; live_atom_d = la; live_copy_d = lc;
          if (blk_end) begin
            if (!found_q && haveres_q && bk_q != resv_q && n == 2'd1 && !lc &&
                32'(la) < ATOM_COUNT) begin
              found_d = 1'b1;
              cb_d = 3'(bk_q); cp_d = 3'(lp); ma_d = la; tb_d = 3'(resv_q);
            end
            live_n_d = '0;
          end
        end
        pg_d = blk_end ? '0 : pg_q + 1'b1;
        if (blk_end) bk_d = bk_q + 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (32'(cnt_q) == Total - 1) begin
          state_d = fpa_pkg::S_DONE;
        end
      end
      fpa_pkg::S_DONE: begin
        done_d = 1'b1;
        state_d = fpa_pkg::S_IDLE;
        case (fpa_pkg::action_e'(act_q))
          fpa_pkg::ACT_WRITE: begin
            ctrl.load = 1'b1;
          end
          fpa_pkg::ACT_ALLOC: begin
            if (found_q) begin
              ctrl.load = 1'b1;
            end else begin
              st_d = fpa_pkg::ST_NO_CAPACITY;
            end
          end
          fpa_pkg::ACT_RELOCATE: begin
            if (!haveres_q) begin
              st_d = fpa_pkg::ST_NO_CAPACITY;
            end else if (!found_q) begin
              st_d = fpa_pkg::ST_NOT_FOUND;
            end
          end
          default: ;
        endcase
      end
      default: state_d = fpa_pkg::S_IDLE;
    endcase
  end

  assign busy = (state_q != fpa_pkg::S_IDLE);
  assign done_o = done_q;
  assign status_o = st_q;
  assign chosen_block_o = cb_q;
  assign chosen_page_o = cp_q;
  assign moved_atom_o = ma_q;
  assign target_block_o = tb_q;

`ifndef SYNTHESIS
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> state_q == fpa_pkg::S_IDLE) else $error("strobe outside idle");
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy) else $error("accept did not raise busy");
  a_done_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q) else $error("double strobe");
`endif
endmodule

[test/flash_page_allocator_relocation_checker.sv]
// Checker: predicts allocator results from accepted requests and compares them.
`timescale 1ns / 1ps
module flash_page_allocator_relocation_checker #(
  parameter int PAGES_PER_BLOCK = 8,
  parameter int DATA_BLOCKS     = 8,
  parameter int ATOM_COUNT      = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  logic       busy_i,
  input  logic [1:0] action_i,
  input  logic [2:0] entry_block_i,
  input  logic [2:0] entry_page_i,
  input  logic [1:0] entry_kind_i,
  input  logic [7:0] entry_atom_i,
  input  logic       entry_is_copy_i,
  input  logic       done_i,
  input  logic [1:0] status_i,
  input  logic [2:0] chosen_block_i,
  input  logic [2:0] chosen_page_i,
  input  logic [7:0] moved_atom_i,
  input  logic [2:0] target_block_i,
  output int         pending_o,
  output int         fail_count_o
);
  localparam int TOTAL = PAGES_PER_BLOCK * DATA_BLOCKS;

  typedef struct packed {
    logic [1:0] status;
    logic [2:0] blk;
    logic [2:0] pg;
    logic [7:0] atom;
    logic [2:0] target;
  } outcome_t;

  fpa_pkg::kind_e tbl_kind [TOTAL];
  logic [7:0] tbl_atom [TOTAL];
  logic       tbl_copy [TOTAL];
  outcome_t   expected_q[$];
  int         fails;

  function automatic outcome_t mk(fpa_pkg::status_e s, int b, int p, int a, int t);
    outcome_t o;
    o.status = s;
    o.blk    = 3'(b);
    o.pg     = 3'(p);
    o.atom   = 8'(a);
    o.target = 3'(t);
    return o;
  endfunction

  function automatic outcome_t predict_outcome(fpa_pkg::action_e act, int b, int p,
                                               fpa_pkg::kind_e k,
                                               logic [7:0] a, logic c);
    int  reserve;
    int  live_n;
    int  live_pg;
    int  idx;
    bit  all_res;
    if (act == fpa_pkg::ACT_WRITE) begin
      if (b < DATA_BLOCKS && p < PAGES_PER_BLOCK) begin
        idx = b * PAGES_PER_BLOCK + p;
        tbl_kind[idx] = k;
        tbl_atom[idx] = a;
        tbl_copy[idx] = c;
      end
      return mk(fpa_pkg::ST_OK, 0, 0, 0, 0);
    end
    if (act == fpa_pkg::ACT_ALLOC) begin
      for (int i = 0; i < TOTAL; i++)
        if (tbl_kind[i] == fpa_pkg::KIND_FREE) begin
          tbl_kind[i] = fpa_pkg::KIND_RESERVED;
          return mk(fpa_pkg::ST_OK, i / PAGES_PER_BLOCK, i % PAGES_PER_BLOCK, 0, 0);
        end
      return mk(fpa_pkg::ST_NO_CAPACITY, 0, 0, 0, 0);
    end
    if (act == fpa_pkg::ACT_RELOCATE) begin
      reserve = -1;
      for (int bb = 0; bb < DATA_BLOCKS; bb++) begin
        all_res = 1;
        for (int pp = 0; pp < PAGES_PER_BLOCK; pp++)
          if (tbl_kind[bb * PAGES_PER_BLOCK + pp] != fpa_pkg::KIND_RESERVED) all_res = 0;
        if (all_res) reserve = bb;
      end
      if (reserve < 0) return mk(fpa_pkg::ST_NO_CAPACITY, 0, 0, 0, 0);
      for (int bb = 0; bb < DATA_BLOCKS; bb++) begin
        if (bb == reserve) continue;
        live_n  = 0;
        live_pg = 0;
        for (int pp = 0; pp < PAGES_PER_BLOCK; pp++)
          if (tbl_kind[bb * PAGES_PER_BLOCK + pp] == fpa_pkg::KIND_LIVE) begin
            live_n++;
            live_pg = pp;
          end
        if (live_n != 1) continue;
        idx = bb * PAGES_PER_BLOCK + live_pg;
        if (tbl_copy[idx] || tbl_atom[idx] >= ATOM_COUNT) continue;
        return mk(fpa_pkg::ST_OK, bb, live_pg, tbl_atom[idx], reserve);
      end
      return mk(fpa_pkg::ST_NOT_FOUND, 0, 0, 0, 0);
    end
    return mk(fpa_pkg::ST_OK, 0, 0, 0, 0);
  endfunction

  initial begin
    fails = 0;
    for (int i = 0; i < TOTAL; i++) begin
      tbl_kind[i] = fpa_pkg::KIND_FREE;
      tbl_atom[i] = '0;
      tbl_copy[i] = 1'b0;
    end
  end

  always @(posedge clk_i) begin
    outcome_t got;
    outcome_t exp_o;
    if (rst_ni) begin
      if (done_i) begin
        got = {status_i, chosen_block_i, chosen_page_i, moved_atom_i, target_block_i};
        if (expected_q.size() == 0) begin
          fails++;
          if (fails <= 10) $display("unexpected result %p", got);
        end else begin
          exp_o = expected_q.pop_front();
          if (got !== exp_o) begin
            fails++;
            if (fails <= 10)
              $display("mismatch: expected %p, got %p", exp_o, got);
          end
        end
      end
      if (start_i && !busy_i)
        expected_q.push_back(predict_outcome(fpa_pkg::action_e'(action_i), entry_block_i,
                                             entry_page_i, fpa_pkg::kind_e'(entry_kind_i),
                                             entry_atom_i, entry_is_copy_i));
    end
  end

  assign pending_o    = expected_q.size();
  assign fail_count_o = fails;
endmodule

[test/flash_page_allocator_relocation_tb.sv]
// Testbench top: drives allocator requests and reports the verdict.
`timescale 1ns / 1ps
module flash_page_allocator_relocation_tb;
  logic       clk_i;
  logic       rst_ni;
  logic       start;
  logic       busy;
  logic [1:0] action_i;
  logic [2:0] entry_block_i;
  logic [2:0] entry_page_i;
  logic [1:0] entry_kind_i;
  logic [7:0] entry_atom_i;
  logic       entry_is_copy_i;
  logic       done_o;
  logic [1:0] status_o;
  logic [2:0] chosen_block_o;
  logic [2:0] chosen_page_o;
  logic [7:0] moved_atom_o;
  logic [2:0] target_block_o;
  int         pending;
  int         fail_count;
  int         sent;

  flash_page_allocator_relocation i_dut (.*);

  flash_page_allocator_relocation_checker i_checker (
    .clk_i, .rst_ni, .start_i(start), .busy_i(busy), .action_i, .entry_block_i,
    .entry_page_i, .entry_kind_i, .entry_atom_i, .entry_is_copy_i,
    .done_i(done_o), .status_i(status_o), .chosen_block_i(chosen_block_o),
    .chosen_page_i(chosen_page_o), .moved_atom_i(moved_atom_o),
    .target_block_i(target_block_o), .pending_o(pending), .fail_count_o(fail_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Called at a falling edge; returns at a falling edge after acceptance, after any random idle gap.
  task automatic issue(fpa_pkg::action_e act, int b, int p, fpa_pkg::kind_e k, int a,
                       bit c);
    int gap;
    action_i        = act;
    entry_block_i   = 3'(b);
    entry_page_i    = 3'(p);
    entry_kind_i    = k;
    entry_atom_i    = 8'(a);
    entry_is_copy_i = c;
    start           = 1'b1;
    while (busy) @(negedge clk_i);
    @(posedge clk_i);
    @(negedge clk_i);
    sent++;
    gap = ($urandom_range(0, 2) == 0) ? 0 :
          ($urandom_range(0, 15) == 0) ? $urandom_range(20, 200) : $urandom_range(1, 4);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  task automatic fill_block(int b, fpa_pkg::kind_e k);
    for (int p = 0; p < 8; p++)
      issue(fpa_pkg::ACT_WRITE, b, p, k, $urandom_range(0, 255), $urandom_range(0, 1) == 1);
  endtask

  // Build a likely relocation candidate: one chosen live page among noise pages, which may also be live.
  task automatic seed_victim(int b);
    int live_pg;
    live_pg = $urandom_range(0, 7);
    for (int p = 0; p < 8; p++)
      if (p == live_pg)
        issue(fpa_pkg::ACT_WRITE, b, p, fpa_pkg::KIND_LIVE, $urandom_range(0, 90),
              $urandom_range(0, 3) == 0);
      else
        issue(fpa_pkg::ACT_WRITE, b, p,
              fpa_pkg::kind_e'($urandom_range(0, 9) == 0 ? fpa_pkg::KIND_LIVE :
              $urandom_range(0, 2) == 0 ? fpa_pkg::KIND_FREE : fpa_pkg::KIND_STALE),
              $urandom_range(0, 255), $urandom_range(0, 1) == 1);
  endtask

  initial begin
    int sel;
    start = 1'b0; action_i = '0; entry_block_i = '0; entry_page_i = '0;
    entry_kind_i = '0; entry_atom_i = '0; entry_is_copy_i = 1'b0;
    sent = 0;
    rst_ni = 1'b0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    issue(fpa_pkg::ACT_RELOCATE, 0, 0, fpa_pkg::KIND_FREE, 0, 0);
    issue(fpa_pkg::ACT_ALLOC, 7, 7, fpa_pkg::KIND_STALE, 255, 1);
    issue(fpa_pkg::ACT_ALLOC, 0, 0, fpa_pkg::KIND_FREE, 0, 0);
    issue(fpa_pkg::ACT_NONE, 7, 7, fpa_pkg::KIND_STALE, 255, 1);
    issue(fpa_pkg::ACT_WRITE, 0, 1, fpa_pkg::KIND_RESERVED, 0, 0);
    issue(fpa_pkg::ACT_WRITE, 7, 3, fpa_pkg::KIND_LIVE, 255, 0);
    issue(fpa_pkg::ACT_WRITE, 7, 4, fpa_pkg::KIND_LIVE, 63, 1);
    issue(fpa_pkg::ACT_WRITE, 3, 0, fpa_pkg::KIND_LIVE, 63, 0);
    issue(fpa_pkg::ACT_WRITE, 5, 7, fpa_pkg::KIND_STALE, 0, 0);
    issue(fpa_pkg::ACT_RELOCATE, 0, 0, fpa_pkg::KIND_FREE, 0, 0);
    issue(fpa_pkg::ACT_WRITE, 0, 7, fpa_pkg::KIND_RESERVED, 64, 0);
    for (int p = 2; p < 7; p++) issue(fpa_pkg::ACT_WRITE, 0, p, fpa_pkg::KIND_RESERVED, 0, 0);
    issue(fpa_pkg::ACT_RELOCATE, 0, 0, fpa_pkg::KIND_FREE, 0, 0);
    issue(fpa_pkg::ACT_WRITE, 3, 0, fpa_pkg::KIND_LIVE, 64, 0);
    issue(fpa_pkg::ACT_RELOCATE, 0, 0, fpa_pkg::KIND_FREE, 0, 0);
    issue(fpa_pkg::ACT_WRITE, 3, 0, fpa_pkg::KIND_FREE, 0, 0);
    issue(fpa_pkg::ACT_WRITE, 0, 0, fpa_pkg::KIND_FREE, 0, 0);
    issue(fpa_pkg::ACT_RELOCATE, 0, 0, fpa_pkg::KIND_FREE, 0, 0);

    while (sent < 900) begin
      if (sent >= 450 && sent < 470) begin
        start = 1'b0;
        wait (pending == 0);
        @(negedge clk_i);
      end
      sel = $urandom_range(0, 9);
      case (sel)
        0, 1: fill_block($urandom_range(0, 7), fpa_pkg::KIND_RESERVED);
        2, 3: seed_victim($urandom_range(0, 7));
        4: begin
          repeat ($urandom_range(0, 7) == 0 ? 70 : $urandom_range(1, 4))
            issue(fpa_pkg::ACT_ALLOC, $urandom_range(0, 7), $urandom_range(0, 7),
                  fpa_pkg::kind_e'($urandom_range(0, 3)), $urandom_range(0, 255),
                  $urandom_range(0, 1) == 1);
        end
        5, 6: issue(fpa_pkg::ACT_RELOCATE, $urandom_range(0, 7), $urandom_range(0, 7),
                    fpa_pkg::kind_e'($urandom_range(0, 3)), $urandom_range(0, 255),
                    $urandom_range(0, 1) == 1);
        7: issue(fpa_pkg::ACT_WRITE, $urandom_range(0, 7), $urandom_range(0, 7),
                 fpa_pkg::kind_e'($urandom_range(0, 3)), $urandom_range(0, 255),
                 $urandom_range(0, 1) == 1);
        8: fill_block($urandom_range(0, 7),
                      fpa_pkg::kind_e'($urandom_range(0, 1) ? fpa_pkg::KIND_FREE :
                                       fpa_pkg::KIND_STALE));
        default: issue(fpa_pkg::ACT_NONE, $urandom_range(0, 7), $urandom_range(0, 7),
                       fpa_pkg::kind_e'($urandom_range(0, 3)), $urandom_range(0, 255),
                       $urandom_range(0, 1) == 1);
      endcase
    end
    start = 1'b0;
    wait (pending == 0);
    repeat (200) @(negedge clk_i);
    if (fail_count == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  initial begin
    #20ms;
    $display("== FAIL ==");
    $finish;
  end
endmodule
